>>> src/gasa_pkg.sv
// Shared types, constants and helper functions of the glyph atlas shelf allocator.
package gasa_pkg;

    localparam int MAX_PAGES = 1024;
    localparam int PAD_ALIGN = 4;
    localparam int PAGE_W = 10;
    localparam int DIM_W = 13;
    localparam int WIDE_W = 15;
    localparam logic [DIM_W-1:0] MAX_PAGE_DIM = 13'd4096;
    localparam logic [DIM_W-1:0] PAGE_DIM_RESET = 13'd256;
    localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(MAX_PAGES - 1);
    localparam logic [WIDE_W-1:0] PAD_MASK = WIDE_W'(PAD_ALIGN - 1);

    // Configuration register indexes.
    localparam logic CFG_PAGE_WIDTH = 1'b0;
    localparam logic CFG_PAGE_HEIGHT = 1'b1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_PLACED = 3'd0,
        ST_EMPTY = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_PAGES = 3'd3,
        ST_RELEASED = 3'd4
    } status_t;

    typedef struct packed {
        op_t         op;
        logic [11:0] glyph_width;
        logic [11:0] glyph_height;
        logic        keep_lock;
    } item_t;

    typedef struct packed {
        logic [DIM_W-1:0]  cursor_x;
        logic [DIM_W-1:0]  cursor_y;
        logic [DIM_W-1:0]  shelf_height;
        logic              have_page;
        logic [PAGE_W-1:0] current_page;
        logic              lock_held;
    } state_t;

    typedef struct packed {
        status_t           status;
        logic [PAGE_W-1:0] page_index;
        logic [11:0]       region_x;
        logic [11:0]       region_y;
        logic [DIM_W-1:0]  region_w;
        logic [DIM_W-1:0]  region_h;
        logic              new_page;
        logic              relock;
        logic [11:0]       lock_x;
        logic [11:0]       lock_y;
        logic [DIM_W-1:0]  lock_w;
        logic [DIM_W-1:0]  lock_h;
    } result_t;

    // Round up to the next multiple of the (power of two) padding alignment.
    function automatic logic [WIDE_W-1:0] pad_up(input logic [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] s;
        s = v + PAD_MASK;
        return s & ~PAD_MASK;
    endfunction

endpackage

>>> src/gasa_place.sv
// Placement logic: one request against the shelf state gives a result and the next state.
module gasa_place (
    input  gasa_pkg::item_t                 item,
    input  gasa_pkg::state_t                cur,
    input  logic [gasa_pkg::DIM_W-1:0]      cfg_page_width,
    input  logic [gasa_pkg::DIM_W-1:0]      cfg_page_height,
    output gasa_pkg::result_t               res,
    output gasa_pkg::state_t                nxt
);

    localparam int WW = gasa_pkg::WIDE_W;
    localparam int DW = gasa_pkg::DIM_W;
    localparam int PW = gasa_pkg::PAGE_W;

    logic [DW-1:0] pw;
    logic [DW-1:0] ph;
    logic [DW-1:0] bw;
    logic [DW-1:0] bh;
    logic [WW-1:0] w4;
    logic [WW-1:0] h4;
    logic          empty_glyph;
    logic          too_large;

    logic [WW-1:0] cx0, cy0, sh0;
    logic [PW-1:0] page0;
    logic          opened0, rel0;

    logic          wrap;
    logic [WW-1:0] cx1, cy1, sh1;

    logic          need_page;
    logic          exhausted;
    logic [WW-1:0] cx2, cy2, sh2;
    logic [PW-1:0] page2;
    logic          opened2, rel2;

    logic          taller;
    logic [WW-1:0] sh3;
    logic          rel3;
    logic [WW-1:0] cx_after;

    assign pw = (cfg_page_width > gasa_pkg::MAX_PAGE_DIM) ? gasa_pkg::MAX_PAGE_DIM
                                                          : cfg_page_width;
    assign ph = (cfg_page_height > gasa_pkg::MAX_PAGE_DIM) ? gasa_pkg::MAX_PAGE_DIM
                                                           : cfg_page_height;

    assign bw = DW'(item.glyph_width) + DW'(2);
    assign bh = DW'(item.glyph_height) + DW'(2);
    assign w4 = gasa_pkg::pad_up(WW'(bw));
    assign h4 = gasa_pkg::pad_up(WW'(bh));

    assign empty_glyph = (item.glyph_width == '0) || (item.glyph_height == '0);
    assign too_large = (w4 > WW'(pw)) || (h4 > WW'(ph));

    // Without a page yet, the first allocation opens page zero at the origin.
    always_comb begin
        if (!cur.have_page) begin
            cx0 = '0;
            cy0 = '0;
            sh0 = '0;
            page0 = '0;
            opened0 = 1'b1;
            rel0 = 1'b1;
        end else begin
            cx0 = WW'(cur.cursor_x);
            cy0 = WW'(cur.cursor_y);
            sh0 = WW'(cur.shelf_height);
            page0 = cur.current_page;
            opened0 = 1'b0;
            rel0 = !cur.lock_held;
        end
    end

    // Start a new shelf below the tallest glyph of the current one.
    assign wrap = (cx0 + w4) > WW'(pw);
    assign cx1 = wrap ? '0 : cx0;
    assign cy1 = wrap ? gasa_pkg::pad_up(cy0 + sh0) : cy0;
    assign sh1 = wrap ? '0 : sh0;

    assign need_page = (cy1 + h4) > WW'(ph);
    assign exhausted = need_page && (page0 >= gasa_pkg::LAST_PAGE);
    assign cx2 = need_page ? '0 : cx1;
    assign cy2 = need_page ? '0 : cy1;
    assign sh2 = need_page ? '0 : sh1;
    assign page2 = need_page ? page0 + PW'(1) : page0;
    assign opened2 = opened0 | need_page;
    assign rel2 = rel0 | wrap | need_page;

    // The lock must grow when this glyph is taller than the shelf so far.
    assign taller = WW'(bh) > sh2;
    assign sh3 = taller ? h4 : sh2;
    assign rel3 = rel2 | taller;
    assign cx_after = gasa_pkg::pad_up(cx2 + w4);

    always_comb begin
        res = '0;
        nxt = cur;
        if (item.op == gasa_pkg::OP_RELEASE) begin
            res.status = gasa_pkg::ST_RELEASED;
            nxt.lock_held = 1'b0;
        end else if (empty_glyph) begin
            res.status = gasa_pkg::ST_EMPTY;
        end else if (too_large) begin
            res.status = gasa_pkg::ST_TOO_LARGE;
        end else if (exhausted) begin
            res.status = gasa_pkg::ST_NO_PAGES;
        end else begin
            res.status = gasa_pkg::ST_PLACED;
            res.page_index = page2;
            res.region_x = cx2[11:0];
            res.region_y = cy2[11:0];
            res.region_w = bw;
            res.region_h = bh;
            res.new_page = opened2;
            res.relock = rel3;
            if (rel3) begin
                res.lock_x = cx2[11:0];
                res.lock_y = cy2[11:0];
                if (item.keep_lock) begin
                    res.lock_w = pw - cx2[DW-1:0];
                    res.lock_h = sh3[DW-1:0];
                end else begin
                    res.lock_w = w4[DW-1:0];
                    res.lock_h = h4[DW-1:0];
                end
            end
            nxt.cursor_x = cx_after[DW-1:0];
            nxt.cursor_y = cy2[DW-1:0];
            nxt.shelf_height = sh3[DW-1:0];
            nxt.current_page = page2;
            nxt.have_page = 1'b1;
            // A kept lock always covers this glyph's shelf; otherwise it is dropped.
            nxt.lock_held = item.keep_lock;
        end
    end

endmodule

>>> src/glyph_atlas_shelf_allocator_core.sv
// Top level of the glyph atlas shelf allocator: request register, placement, result register.
//
// Each request is captured in an input register, resolved by the placement logic and
// stored in a result register when that register is empty or being drained. One request
// is taken every cycle while results are being taken. The shelf state (cursor, shelf
// height, page, lock) is updated at the same edge that loads the result, so the next
// request always sees it. Page size registers are written through the cfg_* port; the
// user must write them only while no request is in flight, as the block does not enforce
// it. Sizes above 4096 act as 4096.
module glyph_atlas_shelf_allocator_core (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [gasa_pkg::DIM_W-1:0]      cfg_wdata,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [11:0]                     s_glyph_width,
    input  logic [11:0]                     s_glyph_height,
    input  logic                            s_keep_lock,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_status,
    output logic [gasa_pkg::PAGE_W-1:0]     m_page_index,
    output logic [11:0]                     m_region_x,
    output logic [11:0]                     m_region_y,
    output logic [gasa_pkg::DIM_W-1:0]      m_region_w,
    output logic [gasa_pkg::DIM_W-1:0]      m_region_h,
    output logic                            m_new_page,
    output logic                            m_relock,
    output logic [11:0]                     m_lock_x,
    output logic [11:0]                     m_lock_y,
    output logic [gasa_pkg::DIM_W-1:0]      m_lock_w,
    output logic [gasa_pkg::DIM_W-1:0]      m_lock_h
);

    logic [gasa_pkg::DIM_W-1:0] page_width_reg;
    logic [gasa_pkg::DIM_W-1:0] page_height_reg;

    logic                in_valid_reg;
    gasa_pkg::item_t     in_item_reg;
    logic                out_valid_reg;
    gasa_pkg::result_t   out_res_reg;
    gasa_pkg::state_t    state_reg;

    gasa_pkg::result_t   res_next;
    gasa_pkg::state_t    state_next;
    logic                advance;

    // The held request moves on when the result register is empty or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_width_reg <= gasa_pkg::PAGE_DIM_RESET;
            page_height_reg <= gasa_pkg::PAGE_DIM_RESET;
        end else if (cfg_we) begin
            if (cfg_index == gasa_pkg::CFG_PAGE_WIDTH) begin
                page_width_reg <= cfg_wdata;
            end else if (cfg_index == gasa_pkg::CFG_PAGE_HEIGHT) begin
                page_height_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.op <= gasa_pkg::op_t'(s_op);
            in_item_reg.glyph_width <= s_glyph_width;
            in_item_reg.glyph_height <= s_glyph_height;
            in_item_reg.keep_lock <= s_keep_lock;
        end
    end

    gasa_place u_place (
        .item            (in_item_reg),
        .cur             (state_reg),
        .cfg_page_width  (page_width_reg),
        .cfg_page_height (page_height_reg),
        .res             (res_next),
        .nxt             (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_status = out_res_reg.status;
    assign m_page_index = out_res_reg.page_index;
    assign m_region_x = out_res_reg.region_x;
    assign m_region_y = out_res_reg.region_y;
    assign m_region_w = out_res_reg.region_w;
    assign m_region_h = out_res_reg.region_h;
    assign m_new_page = out_res_reg.new_page;
    assign m_relock = out_res_reg.relock;
    assign m_lock_x = out_res_reg.lock_x;
    assign m_lock_y = out_res_reg.lock_y;
    assign m_lock_w = out_res_reg.lock_w;
    assign m_lock_h = out_res_reg.lock_h;

endmodule

>>> verif/tb_glyph_atlas_shelf_allocator_core.sv
// Self-checking testbench for the glyph atlas shelf allocator core.
module tb_glyph_atlas_shelf_allocator_core;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int DIM_W = gasa_pkg::DIM_W;
    localparam int PAGE_W = gasa_pkg::PAGE_W;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = gasa_pkg::CFG_PAGE_WIDTH;
    logic [DIM_W-1:0]    cfg_wdata = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_op = gasa_pkg::OP_ALLOC;
    logic [11:0]         s_glyph_width = '0;
    logic [11:0]         s_glyph_height = '0;
    logic                s_keep_lock = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [2:0]          m_status;
    logic [PAGE_W-1:0]   m_page_index;
    logic [11:0]         m_region_x;
    logic [11:0]         m_region_y;
    logic [DIM_W-1:0]    m_region_w;
    logic [DIM_W-1:0]    m_region_h;
    logic                m_new_page;
    logic                m_relock;
    logic [11:0]         m_lock_x;
    logic [11:0]         m_lock_y;
    logic [DIM_W-1:0]    m_lock_w;
    logic [DIM_W-1:0]    m_lock_h;

    glyph_atlas_shelf_allocator_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_glyph_width  (s_glyph_width),
        .s_glyph_height (s_glyph_height),
        .s_keep_lock    (s_keep_lock),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_page_index   (m_page_index),
        .m_region_x     (m_region_x),
        .m_region_y     (m_region_y),
        .m_region_w     (m_region_w),
        .m_region_h     (m_region_h),
        .m_new_page     (m_new_page),
        .m_relock       (m_relock),
        .m_lock_x       (m_lock_x),
        .m_lock_y       (m_lock_y),
        .m_lock_w       (m_lock_w),
        .m_lock_h       (m_lock_h)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the page size registers and the shelf state.
    logic [DIM_W-1:0] atlas_w = gasa_pkg::PAGE_DIM_RESET;
    logic [DIM_W-1:0] atlas_h = gasa_pkg::PAGE_DIM_RESET;
    int unsigned      shelf_x = 0;
    int unsigned      shelf_y = 0;
    int unsigned      shelf_h = 0;
    int unsigned      page_no = 0;
    bit               page_open = 1'b0;
    bit               lock_on = 1'b0;

    gasa_pkg::item_t   glyph_requests[$];
    gasa_pkg::result_t due_placements[$];
    gasa_pkg::item_t   cur_req;
    gasa_pkg::result_t want;
    bit          took_req = 1'b0;
    int unsigned requests_queued = 0;
    int unsigned results_taken = 0;
    int unsigned mismatches = 0;
    int unsigned stuck_cycles = 0;
    int unsigned send_wait = 0;
    int unsigned send_calm = 0;
    int unsigned sink_wait = 0;
    int unsigned sink_calm = 0;

    function automatic int unsigned align4(input int unsigned v);
        return ((v + gasa_pkg::PAD_ALIGN - 1) / gasa_pkg::PAD_ALIGN) * gasa_pkg::PAD_ALIGN;
    endfunction

    // Places one request on the shadow atlas and returns the result it must produce.
    function automatic gasa_pkg::result_t pack_glyph(input gasa_pkg::item_t req);
        gasa_pkg::result_t r;
        int unsigned pw, ph, bw, bh, w4, h4, cx, cy, sh, pg, rx, ry;
        bit          opened, relock;
        r = '0;
        pw = 32'((atlas_w > gasa_pkg::MAX_PAGE_DIM) ? gasa_pkg::MAX_PAGE_DIM : atlas_w);
        ph = 32'((atlas_h > gasa_pkg::MAX_PAGE_DIM) ? gasa_pkg::MAX_PAGE_DIM : atlas_h);
        if (req.op == gasa_pkg::OP_RELEASE) begin
            lock_on = 1'b0;
            r.status = gasa_pkg::ST_RELEASED;
            return r;
        end
        if (req.glyph_width == 0 || req.glyph_height == 0) begin
            r.status = gasa_pkg::ST_EMPTY;
            return r;
        end
        bw = 32'(req.glyph_width) + 2;
        bh = 32'(req.glyph_height) + 2;
        w4 = align4(bw);
        h4 = align4(bh);
        if (w4 > pw || h4 > ph) begin
            r.status = gasa_pkg::ST_TOO_LARGE;
            return r;
        end
        cx = shelf_x;
        cy = shelf_y;
        sh = shelf_h;
        pg = page_no;
        opened = 1'b0;
        if (!page_open) begin
            opened = 1'b1;
            pg = 0;
            cx = 0;
            cy = 0;
            sh = 0;
            relock = 1'b1;
        end else begin
            relock = !lock_on;
        end
        // Start a new shelf below the tallest glyph of this one.
        if (cx + w4 > pw) begin
            cy = align4(cy + sh);
            cx = 0;
            sh = 0;
            relock = 1'b1;
        end
        if (cy + h4 > ph) begin
            if (pg + 1 >= gasa_pkg::MAX_PAGES) begin
                r.status = gasa_pkg::ST_NO_PAGES;
                return r;
            end
            pg = pg + 1;
            opened = 1'b1;
            cx = 0;
            cy = 0;
            sh = 0;
            relock = 1'b1;
        end
        r.status = gasa_pkg::ST_PLACED;
        r.page_index = PAGE_W'(pg);
        r.region_x = 12'(cx);
        r.region_y = 12'(cy);
        r.region_w = DIM_W'(bw);
        r.region_h = DIM_W'(bh);
        r.new_page = opened;
        rx = cx;
        ry = cy;
        cx = align4(cx + w4);
        if (bh > sh) begin
            sh = h4;
            relock = 1'b1;
        end
        if (relock) begin
            r.relock = 1'b1;
            r.lock_x = 12'(rx);
            r.lock_y = 12'(ry);
            r.lock_w = req.keep_lock ? DIM_W'(pw - rx) : DIM_W'(w4);
            r.lock_h = req.keep_lock ? DIM_W'(sh) : DIM_W'(h4);
            lock_on = 1'b1;
        end
        if (!req.keep_lock)
            lock_on = 1'b0;
        shelf_x = cx & 32'h1FFF;
        shelf_y = cy & 32'h1FFF;
        shelf_h = sh & 32'h1FFF;
        page_no = pg;
        page_open = 1'b1;
        return r;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic int unsigned glyph_limit(input logic [DIM_W-1:0] dim);
        int unsigned eff;
        eff = 32'((dim > gasa_pkg::MAX_PAGE_DIM) ? gasa_pkg::MAX_PAGE_DIM : dim);
        return (eff >= 3) ? eff - 2 : 1;
    endfunction

    task automatic push_req(input gasa_pkg::op_t op, input logic [11:0] w,
                            input logic [11:0] h, input logic more);
        gasa_pkg::item_t it;
        it.op = op;
        it.glyph_width = w;
        it.glyph_height = h;
        it.keep_lock = more;
        glyph_requests.push_back(it);
        requests_queued++;
    endtask

    // Mostly lock-holding runs of sensible glyphs closed by a release, plus odd requests.
    task automatic push_random_glyph(input int unsigned lim_w, input int unsigned lim_h);
        int unsigned r, w, h;
        logic        more;
        r = $urandom_range(0, 99);
        more = ($urandom_range(0, 3) != 0);
        if (r < 10) begin
            push_req(gasa_pkg::OP_RELEASE, 12'($urandom_range(0, 4095)),
                     12'($urandom_range(0, 4095)), more);
        end else if (r < 15) begin
            w = $urandom_range(0, 4095);
            if ($urandom_range(0, 1) == 0)
                push_req(gasa_pkg::OP_ALLOC, 12'd0, 12'(w), more);
            else
                push_req(gasa_pkg::OP_ALLOC, 12'(w), 12'd0, more);
        end else if (r < 23) begin
            push_req(gasa_pkg::OP_ALLOC, 12'($urandom_range(0, 4095)),
                     12'($urandom_range(0, 4095)), more);
        end else if (r < 70) begin
            w = $urandom_range(1, (lim_w < 16) ? lim_w : 16);
            h = $urandom_range(1, (lim_h < 16) ? lim_h : 16);
            push_req(gasa_pkg::OP_ALLOC, 12'(w), 12'(h), more);
        end else begin
            push_req(gasa_pkg::OP_ALLOC, 12'($urandom_range(1, lim_w)),
                     12'($urandom_range(1, lim_h)), more);
        end
    endtask

    // Waits until every queued request has returned its result.
    task automatic settle();
        while (results_taken < requests_queued)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_page_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= gasa_pkg::CFG_PAGE_WIDTH;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_index <= gasa_pkg::CFG_PAGE_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_we <= 1'b0;
        atlas_w = w;
        atlas_h = h;
    endtask

    // The sender pauses halfway through each phase until all results are back.
    task automatic random_phase(input int unsigned n);
        int unsigned lim_w, lim_h;
        lim_w = glyph_limit(atlas_w);
        lim_h = glyph_limit(atlas_h);
        for (int unsigned i = 0; i < n; i++) begin
            if (i == n / 2)
                settle();
            push_random_glyph(lim_w, lim_h);
        end
    endtask

    task automatic check_field(input string name, input logic [DIM_W-1:0] exp_v,
                               input logic [DIM_W-1:0] got_v);
        if (got_v !== exp_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0d, got %0d",
                         results_taken, name, exp_v, got_v);
        end
    endtask

    always @(negedge aclk) begin
        if (send_calm > 0)
            send_calm--;
        else if ($urandom_range(0, 99) < 2)
            send_calm = $urandom_range(20, 80);
        if (took_req || !s_valid) begin
            took_req = 1'b0;
            if (send_wait > 0) begin
                send_wait--;
                s_valid <= 1'b0;
            end else if (glyph_requests.size() != 0) begin
                cur_req = glyph_requests.pop_front();
                s_op <= cur_req.op;
                s_glyph_width <= cur_req.glyph_width;
                s_glyph_height <= cur_req.glyph_height;
                s_keep_lock <= cur_req.keep_lock;
                s_valid <= 1'b1;
                send_wait = (send_calm > 0) ? 0 : idle_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (sink_calm > 0)
            sink_calm--;
        else if ($urandom_range(0, 99) < 3)
            sink_calm = $urandom_range(20, 80);
        if (sink_wait > 0) begin
            sink_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            sink_wait = (sink_calm > 0) ? 0 : idle_len();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            due_placements.push_back(pack_glyph(cur_req));
            took_req = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_taken++;
            if (due_placements.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with no request pending, status %0d",
                             results_taken, m_status);
            end else begin
                want = due_placements.pop_front();
                check_field("status", DIM_W'(want.status), DIM_W'(m_status));
                check_field("page_index", DIM_W'(want.page_index), DIM_W'(m_page_index));
                check_field("region_x", DIM_W'(want.region_x), DIM_W'(m_region_x));
                check_field("region_y", DIM_W'(want.region_y), DIM_W'(m_region_y));
                check_field("region_w", want.region_w, m_region_w);
                check_field("region_h", want.region_h, m_region_h);
                check_field("new_page", DIM_W'(want.new_page), DIM_W'(m_new_page));
                check_field("relock", DIM_W'(want.relock), DIM_W'(m_relock));
                check_field("lock_x", DIM_W'(want.lock_x), DIM_W'(m_lock_x));
                check_field("lock_y", DIM_W'(want.lock_y), DIM_W'(m_lock_y));
                check_field("lock_w", want.lock_w, m_lock_w);
                check_field("lock_h", want.lock_h, m_lock_h);
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
                $display("tb_glyph_atlas_shelf_allocator_core NOT OK");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Default 256 x 256 pages: release before any page, empty and oversized glyphs,
        // lock runs and a glyph that only fits on a fresh page.
        push_req(gasa_pkg::OP_RELEASE, 12'd0, 12'd0, 1'b0);
        push_req(gasa_pkg::OP_ALLOC, 12'd0, 12'd5, 1'b1);
        push_req(gasa_pkg::OP_ALLOC, 12'd7, 12'd0, 1'b0);
        push_req(gasa_pkg::OP_ALLOC, 12'd4095, 12'd4095, 1'b1);
        push_req(gasa_pkg::OP_ALLOC, 12'd255, 12'd10, 1'b0);
        push_req(gasa_pkg::OP_ALLOC, 12'd10, 12'd254, 1'b1);
        push_req(gasa_pkg::OP_ALLOC, 12'd1, 12'd1, 1'b1);
        push_req(gasa_pkg::OP_ALLOC, 12'd1, 12'd1, 1'b1);
        push_req(gasa_pkg::OP_ALLOC, 12'd3, 12'd3, 1'b1);
        push_req(gasa_pkg::OP_RELEASE, 12'd4095, 12'd4095, 1'b1);
        push_req(gasa_pkg::OP_ALLOC, 12'd2, 12'd2, 1'b0);
        push_req(gasa_pkg::OP_ALLOC, 12'd253, 12'd253, 1'b1);

        set_page_size(13'd4096, 13'd4096);
        push_req(gasa_pkg::OP_ALLOC, 12'd4094, 12'd4094, 1'b0);
        push_req(gasa_pkg::OP_ALLOC, 12'd4094, 12'd1, 1'b1);
        push_req(gasa_pkg::OP_ALLOC, 12'd4095, 12'd1, 1'b0);
        push_req(gasa_pkg::OP_ALLOC, 12'd1, 12'd4095, 1'b1);

        // Register values beyond 4096 behave as 4096.
        set_page_size(13'd8191, 13'd8191);
        push_req(gasa_pkg::OP_ALLOC, 12'd4094, 12'd4094, 1'b1);
        push_req(gasa_pkg::OP_RELEASE, 12'd0, 12'd0, 1'b0);

        // Sizes that are not a multiple of four are used as written.
        set_page_size(13'd250, 13'd130);
        push_req(gasa_pkg::OP_ALLOC, 12'd246, 12'd7, 1'b1);
        push_req(gasa_pkg::OP_ALLOC, 12'd247, 12'd7, 1'b0);
        push_req(gasa_pkg::OP_ALLOC, 12'd5, 12'd126, 1'b1);
        push_req(gasa_pkg::OP_ALLOC, 12'd5, 12'd127, 1'b1);

        set_page_size(13'd0, 13'd4096);
        push_req(gasa_pkg::OP_ALLOC, 12'd1, 12'd1, 1'b0);

        set_page_size(13'd256, 13'd256);
        random_phase(60);
        set_page_size(13'd4096, 13'd4096);
        random_phase(80);
        set_page_size(13'd64, 13'd32);
        random_phase(80);
        set_page_size(13'd4, 13'd4096);
        random_phase(40);
        set_page_size(13'd4096, 13'd4);
        random_phase(40);
        set_page_size(13'd8, 13'd12);
        random_phase(40);
        set_page_size(13'd8191, 13'd1000);
        random_phase(60);
        set_page_size(13'($urandom_range(4, 4096)), 13'($urandom_range(4, 4096)));
        random_phase(80);
        set_page_size(13'($urandom_range(4, 4096)), 13'($urandom_range(4, 4096)));
        random_phase(80);

        // Tiny 4 x 4 pages: every glyph that fits opens a page of its own.
        set_page_size(13'd4, 13'd4);
        random_phase(40);

        settle();
        repeat (10) @(posedge aclk);
        if (due_placements.size() != 0) begin
            mismatches += due_placements.size();
            $display("%0d expected results never arrived", due_placements.size());
        end
        if (mismatches == 0)
            $display("tb_glyph_atlas_shelf_allocator_core OK");
        else
            $display("tb_glyph_atlas_shelf_allocator_core NOT OK");
        $finish;
    end

endmodule

>>> files.f
src/gasa_pkg.sv
src/gasa_place.sv
src/glyph_atlas_shelf_allocator_core.sv
verif/tb_glyph_atlas_shelf_allocator_core.sv
